// ----- sv/pwmc_pkg.sv -----
// ----------------------------------------------------------------------------
// PWM calculator package
// Shared widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package pwmc_pkg;

    localparam int CLK_W     = 28;
    localparam int FREQ_W    = 24;
    localparam int DUTY_W    = 8;
    localparam int VAL_W     = 16;
    localparam int DIV_W     = 28;
    localparam int CFG_IDX_W = 2;

    localparam int COUNTER_BITS_DEFAULT = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_FREQ    = 2'd1;

    localparam logic [CLK_W-1:0]  TIMER_CLOCK_RESET = 28'd84000000;
    localparam logic [FREQ_W-1:0] PWM_FREQ_RESET    = 24'd20000;

    localparam logic [DUTY_W-1:0] PERCENT_FULL = 8'd100;
    localparam logic [DIV_W-1:0]  VAL_MAX      = 28'd65535;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_Q,
        ST_DIV_PSC,
        ST_DIV_PER,
        ST_MUL,
        ST_DIV_CMP,
        ST_OUT
    } state_t;

endpackage

// ----- sv/pwmc_div.sv -----
// ----------------------------------------------------------------------------
// PWM calculator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwmc_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pwmc_pkg::DIV_W-1:0]  dividend,
    input  logic [pwmc_pkg::DIV_W-1:0]  divisor,
    output logic                        done,
    output logic [pwmc_pkg::DIV_W-1:0]  quotient
);

    localparam int W     = pwmc_pkg::DIV_W;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;

    logic [W:0]       shifted;
    logic [W:0]       reduced;
    logic             fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[W-1]};
        reduced = shifted - {1'b0, dvs_reg};
        fits    = !reduced[W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? reduced[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/pwm_period_and_duty_calculator.sv -----
// ----------------------------------------------------------------------------
// PWM period and duty calculator
// Forms timer prescaler, period and compare values from clock, frequency
// and a duty percentage.
// ----------------------------------------------------------------------------
// Usage: software writes timer_clock_hz (index 0) and pwm_freq_hz (index 1)
// through the write port while the block is idle. Each input word on the
// in_valid/in_ready channel carries a duty percentage; one result word
// (prescaler, period, compare value, fault flag) leaves on the
// out_valid/out_ready channel for each input word.
// With the timing formed, a word takes one multiply and one divide by 100 on
// the shared 28-bit divider; the next word is taken only once its result
// has moved to the output register.
// The first word after reset or after a write to index 0 or 1 forms the
// timing again: a check state and three divider passes (clock over
// frequency, quotient over the period limit plus two, quotient over
// prescaler plus one) come before its multiply and divide.
// A fault found in the check state or the prescaler pass, or one already
// stored, goes straight to the output state. Only one word is worked on at a time.
// Reset restores the register defaults and marks the timing as not formed.
// A finished result waits in the output register while the receiver
// stalls; the block can take the next word meanwhile but holds its next
// result until the output register is free.
// ----------------------------------------------------------------------------
module pwm_period_and_duty_calculator
#(
    parameter int COUNTER_BITS = pwmc_pkg::COUNTER_BITS_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [pwmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwmc_pkg::CLK_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pwmc_pkg::DUTY_W-1:0]     duty_pct,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pwmc_pkg::VAL_W-1:0]      prescaler_value,
    output logic [pwmc_pkg::VAL_W-1:0]      period_value,
    output logic [pwmc_pkg::VAL_W-1:0]      compare_value,
    output logic                            config_fault
);

    localparam int W       = pwmc_pkg::DIV_W;
    localparam int VW      = pwmc_pkg::VAL_W;
    localparam int LIM_INT = (COUNTER_BITS >= 16) ? 65535 : ((1 << COUNTER_BITS) - 1);
    localparam logic [W-1:0] LIM    = W'(LIM_INT);
    localparam logic [W-1:0] LIM_P2 = W'(LIM_INT + 2);

    pwmc_pkg::state_t state_reg, state_next;

    logic [pwmc_pkg::CLK_W-1:0]  clock_reg;
    logic [pwmc_pkg::FREQ_W-1:0] freq_reg;
    logic                        timing_valid_reg, timing_valid_next;
    logic [VW-1:0]               psc_reg, psc_next;
    logic [VW-1:0]               per_reg, per_next;
    logic                        fault_reg, fault_next;
    logic [6:0]                  duty_reg, duty_next;
    logic [W-1:0]                q_reg, q_next;
    logic [VW-1:0]               cmp_reg, cmp_next;
    logic                        out_valid_reg, out_valid_next;
    logic [VW-1:0]               out_psc_reg, out_psc_next;
    logic [VW-1:0]               out_per_reg, out_per_next;
    logic [VW-1:0]               out_cmp_reg, out_cmp_next;
    logic                        out_fault_reg, out_fault_next;

    logic                        div_start;
    logic [W-1:0]                div_dividend;
    logic [W-1:0]                div_divisor;
    logic                        div_done;
    logic [W-1:0]                div_quotient;

    logic                        in_accept;
    logic                        cfg_hit;
    logic [W-1:0]                per_wide;
    logic [23:0]                 product;

    pwmc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign in_ready  = (state_reg == pwmc_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign cfg_hit   = cfg_write_en && ((cfg_index == pwmc_pkg::REG_TIMER_CLOCK)
                                     || (cfg_index == pwmc_pkg::REG_PWM_FREQ));

    always_comb
    begin
        state_next        = state_reg;
        timing_valid_next = timing_valid_reg;
        psc_next          = psc_reg;
        per_next          = per_reg;
        fault_next        = fault_reg;
        duty_next         = duty_reg;
        q_next            = q_reg;
        cmp_next          = cmp_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_psc_next      = out_psc_reg;
        out_per_next      = out_per_reg;
        out_cmp_next      = out_cmp_reg;
        out_fault_next    = out_fault_reg;
        div_start         = 1'b0;
        div_dividend      = '0;
        div_divisor       = '0;
        per_wide          = div_quotient - 1'b1;
        product           = {7'd0, ({1'b0, per_reg} + 17'd1)} * {17'd0, duty_reg};

        unique case (state_reg)
            pwmc_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    duty_next = (duty_pct > pwmc_pkg::PERCENT_FULL)
                              ? pwmc_pkg::PERCENT_FULL[6:0] : duty_pct[6:0];
                    if (!timing_valid_reg)
                    begin
                        state_next = pwmc_pkg::ST_CHECK;
                    end
                    else if (fault_reg)
                    begin
                        cmp_next   = '0;
                        state_next = pwmc_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = pwmc_pkg::ST_MUL;
                    end
                end
            end
            pwmc_pkg::ST_CHECK:
            begin
                timing_valid_next = 1'b1;
                if ((freq_reg == '0) || ({4'd0, freq_reg} > clock_reg))
                begin
                    psc_next   = '0;
                    per_next   = '0;
                    fault_next = 1'b1;
                    cmp_next   = '0;
                    state_next = pwmc_pkg::ST_OUT;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = clock_reg;
                    div_divisor  = {4'd0, freq_reg};
                    state_next   = pwmc_pkg::ST_DIV_Q;
                end
            end
            pwmc_pkg::ST_DIV_Q:
            begin
                if (div_done)
                begin
                    q_next       = div_quotient;
                    div_start    = 1'b1;
                    div_dividend = div_quotient;
                    div_divisor  = LIM_P2;
                    state_next   = pwmc_pkg::ST_DIV_PSC;
                end
            end
            pwmc_pkg::ST_DIV_PSC:
            begin
                if (div_done)
                begin
                    if (div_quotient > pwmc_pkg::VAL_MAX)
                    begin
                        psc_next   = '0;
                        per_next   = '0;
                        fault_next = 1'b1;
                        cmp_next   = '0;
                        state_next = pwmc_pkg::ST_OUT;
                    end
                    else
                    begin
                        psc_next     = div_quotient[VW-1:0];
                        div_start    = 1'b1;
                        div_dividend = q_reg;
                        div_divisor  = div_quotient + 1'b1;
                        state_next   = pwmc_pkg::ST_DIV_PER;
                    end
                end
            end
            pwmc_pkg::ST_DIV_PER:
            begin
                if (div_done)
                begin
                    per_next   = (per_wide > LIM) ? LIM[VW-1:0] : per_wide[VW-1:0];
                    fault_next = 1'b0;
                    state_next = pwmc_pkg::ST_MUL;
                end
            end
            pwmc_pkg::ST_MUL:
            begin
                div_start    = 1'b1;
                div_dividend = {4'd0, product};
                div_divisor  = W'(pwmc_pkg::PERCENT_FULL);
                state_next   = pwmc_pkg::ST_DIV_CMP;
            end
            pwmc_pkg::ST_DIV_CMP:
            begin
                if (div_done)
                begin
                    cmp_next   = (div_quotient > {12'd0, per_reg})
                               ? per_reg : div_quotient[VW-1:0];
                    state_next = pwmc_pkg::ST_OUT;
                end
            end
            pwmc_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_psc_next   = psc_reg;
                    out_per_next   = per_reg;
                    out_cmp_next   = cmp_reg;
                    out_fault_next = fault_reg;
                    state_next     = pwmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pwmc_pkg::ST_IDLE;
            end
        endcase

        if (cfg_hit)
        begin
            timing_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pwmc_pkg::ST_IDLE;
            clock_reg        <= pwmc_pkg::TIMER_CLOCK_RESET;
            freq_reg         <= pwmc_pkg::PWM_FREQ_RESET;
            timing_valid_reg <= 1'b0;
            psc_reg          <= '0;
            per_reg          <= '0;
            fault_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            timing_valid_reg <= timing_valid_next;
            psc_reg          <= psc_next;
            per_reg          <= per_next;
            fault_reg        <= fault_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_write_en && (cfg_index == pwmc_pkg::REG_TIMER_CLOCK))
            begin
                clock_reg <= cfg_data;
            end
            if (cfg_write_en && (cfg_index == pwmc_pkg::REG_PWM_FREQ))
            begin
                freq_reg <= cfg_data[pwmc_pkg::FREQ_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        duty_reg      <= duty_next;
        q_reg         <= q_next;
        cmp_reg       <= cmp_next;
        out_psc_reg   <= out_psc_next;
        out_per_reg   <= out_per_next;
        out_cmp_reg   <= out_cmp_next;
        out_fault_reg <= out_fault_next;
    end

    assign out_valid       = out_valid_reg;
    assign prescaler_value = out_psc_reg;
    assign period_value    = out_per_reg;
    assign compare_value   = out_cmp_reg;
    assign config_fault    = out_fault_reg;

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// PWM period and duty calculator testbench
// Sends duty words under many timer clock and frequency settings, predicts
// prescaler, period, compare value and fault flag for each word, and checks
// every result word in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [pwmc_pkg::DUTY_W-1:0] duty_t;
    typedef logic [pwmc_pkg::CLK_W-1:0]  cfg_word_t;

    localparam logic [pwmc_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [pwmc_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam longint unsigned PERIOD_CAP =
        (pwmc_pkg::COUNTER_BITS_DEFAULT >= 16) ? 64'd65535 :
        (64'd1 << pwmc_pkg::COUNTER_BITS_DEFAULT) - 64'd1;
    localparam int RANDOM_WORDS = 680;
    localparam int STALL_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 150;

    typedef struct {
        logic [pwmc_pkg::VAL_W-1:0] prescaler;
        logic [pwmc_pkg::VAL_W-1:0] period;
        logic [pwmc_pkg::VAL_W-1:0] compare;
        logic                       fault;
    } pwm_word_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write_en;
    logic [pwmc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pwmc_pkg::CLK_W-1:0]     cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [pwmc_pkg::DUTY_W-1:0]    duty_pct;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [pwmc_pkg::VAL_W-1:0]     prescaler_value;
    logic [pwmc_pkg::VAL_W-1:0]     period_value;
    logic [pwmc_pkg::VAL_W-1:0]     compare_value;
    logic                           config_fault;

    // Shadow of the block's registers and its kept timing.
    logic [pwmc_pkg::CLK_W-1:0]  clock_hz;
    logic [pwmc_pkg::FREQ_W-1:0] freq_hz;
    logic                        timing_formed;
    logic [pwmc_pkg::VAL_W-1:0]  held_prescaler;
    logic [pwmc_pkg::VAL_W-1:0]  held_period;
    logic                        held_fault;

    pwm_word_t pending_results[$];

    int fail_count    = 0;
    int words_sent;
    int results_seen  = 0;
    int fault_results = 0;
    int settings_used;
    int idle_cycles   = 0;
    int calm_words;
    int ready_left    = 0;

    pwm_period_and_duty_calculator u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .duty_pct        (duty_pct),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .prescaler_value (prescaler_value),
        .period_value    (period_value),
        .compare_value   (compare_value),
        .config_fault    (config_fault)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void form_timing();
        longint unsigned quot;
        longint unsigned psc;
        longint unsigned per;
        timing_formed  = 1'b1;
        held_prescaler = '0;
        held_period    = '0;
        held_fault     = 1'b1;
        if (freq_hz != 0 && freq_hz <= clock_hz)
        begin
            quot = 64'(clock_hz) / 64'(freq_hz);
            psc  = quot / (PERIOD_CAP + 64'd2);
            if (psc <= 64'd65535)
            begin
                per = quot / (psc + 64'd1) - 64'd1;
                if (per > PERIOD_CAP)
                    per = PERIOD_CAP;
                held_prescaler = psc[pwmc_pkg::VAL_W-1:0];
                held_period    = per[pwmc_pkg::VAL_W-1:0];
                held_fault     = 1'b0;
            end
        end
    endfunction

    function automatic pwm_word_t predict_pwm_word(logic [pwmc_pkg::DUTY_W-1:0] duty);
        pwm_word_t       res;
        longint unsigned pct;
        longint unsigned cmp;
        if (!timing_formed)
            form_timing();
        pct = 64'((duty > pwmc_pkg::PERCENT_FULL) ? pwmc_pkg::PERCENT_FULL : duty);
        res.prescaler = '0;
        res.period    = '0;
        res.compare   = '0;
        res.fault     = held_fault;
        if (!held_fault)
        begin
            cmp = ((64'(held_period) + 64'd1) * pct) / 64'(pwmc_pkg::PERCENT_FULL);
            if (cmp > 64'(held_period))
                cmp = 64'(held_period);
            res.prescaler = held_prescaler;
            res.period    = held_period;
            res.compare   = cmp[pwmc_pkg::VAL_W-1:0];
        end
        return res;
    endfunction

    task automatic check_field(string name, logic [pwmc_pkg::VAL_W-1:0] exp_val,
                               logic [pwmc_pkg::VAL_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        pwm_word_t exp_word;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result word with none expected, got %0d/%0d/%0d/%0d",
                         $time, prescaler_value, period_value, compare_value,
                         config_fault);
                fail_count++;
            end
            else
            begin
                exp_word = pending_results.pop_front();
                results_seen++;
                if (exp_word.fault)
                    fault_results++;
                check_field("prescaler_value", exp_word.prescaler, prescaler_value);
                check_field("period_value", exp_word.period, period_value);
                check_field("compare_value", exp_word.compare, compare_value);
                check_field("config_fault", {15'd0, exp_word.fault}, {15'd0, config_fault});
            end
        end
    end

    always @(posedge clk)
    begin
        int unsigned pick;
        if (ready_left > 0)
        begin
            ready_left--;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                out_ready  <= 1'b1;
                ready_left = $urandom_range(50, 200);
            end
            else if (pick < 55)
            begin
                out_ready  <= 1'b1;
                ready_left = $urandom_range(0, 5);
            end
            else if (pick < 90)
            begin
                out_ready  <= 1'b0;
                ready_left = $urandom_range(0, 3);
            end
            else
            begin
                out_ready  <= 1'b0;
                ready_left = $urandom_range(15, 60);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL pwm_period_and_duty_calculator");
            $finish;
        end
    end

    function automatic int source_gap();
        int unsigned pick;
        if (calm_words > 0)
        begin
            calm_words--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            calm_words = $urandom_range(10, 40);
            return 0;
        end
        else if (pick < 50)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(logic [pwmc_pkg::DUTY_W-1:0] duty);
        int gap;
        gap = source_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        duty_pct <= duty;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_pwm_word(duty));
        words_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(logic [pwmc_pkg::CFG_IDX_W-1:0] idx,
                                logic [pwmc_pkg::CLK_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        if (idx == pwmc_pkg::REG_TIMER_CLOCK)
        begin
            clock_hz      = data;
            timing_formed = 1'b0;
        end
        else if (idx == pwmc_pkg::REG_PWM_FREQ)
        begin
            freq_hz       = data[pwmc_pkg::FREQ_W-1:0];
            timing_formed = 1'b0;
        end
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_timing(logic [pwmc_pkg::CLK_W-1:0] clk_val,
                                logic [pwmc_pkg::CLK_W-1:0] freq_val);
        wait_idle();
        write_config(pwmc_pkg::REG_TIMER_CLOCK, clk_val);
        write_config(pwmc_pkg::REG_PWM_FREQ, freq_val);
        settings_used++;
    endtask

    task automatic test_reset_timing();
        send_word(8'd0);
        send_word(8'd1);
        send_word(8'd50);
        send_word(8'd99);
        send_word(pwmc_pkg::PERCENT_FULL);
        send_word(8'd101);
        send_word(8'd200);
        send_word(8'd255);
    endtask

    task automatic test_timing_extremes();
        apply_timing(28'hFFFFFFF, 28'd1);
        send_word(8'd255);
        send_word(8'd33);
        apply_timing(28'd1, 28'd1);
        send_word(pwmc_pkg::PERCENT_FULL);
        apply_timing(28'd65537, 28'd1);
        send_word(8'd77);
        apply_timing(28'd65536, 28'd1);
        send_word(pwmc_pkg::PERCENT_FULL);
        apply_timing(28'd200000000, 28'd10000000);
        send_word(8'd50);
        // Upper data bits beyond the frequency register must be dropped.
        wait_idle();
        write_config(pwmc_pkg::REG_PWM_FREQ, 28'hFFFFFFF);
        send_word(8'd50);
        wait_idle();
        write_config(REG_SPARE_2, 28'h0000001);
        write_config(REG_SPARE_3, 28'hFFFFFFF);
        send_word(8'd25);
    endtask

    task automatic test_fault_cases();
        apply_timing(28'd1000, 28'd1001);
        send_word(8'd60);
        apply_timing(28'd1000, 28'd0);
        send_word(8'd255);
        apply_timing(28'd0, 28'd5);
        send_word(8'd10);
        apply_timing(pwmc_pkg::TIMER_CLOCK_RESET, {4'd0, pwmc_pkg::PWM_FREQ_RESET});
        send_word(pwmc_pkg::PERCENT_FULL);
    endtask

    task automatic pick_random_setting();
        int unsigned mode;
        int          width;
        cfg_word_t   clk_val;
        cfg_word_t   freq_val;
        mode = $urandom_range(0, 99);
        if (mode < 65)
        begin
            clk_val  = cfg_word_t'($urandom_range(1, 200000000));
            width    = $urandom_range(0, 23);
            freq_val = cfg_word_t'($urandom_range(1, 1 << width));
            if (freq_val > clk_val)
                freq_val = cfg_word_t'($urandom_range(1, clk_val));
            apply_timing(clk_val, freq_val);
        end
        else if (mode < 75)
        begin
            clk_val  = cfg_word_t'($urandom_range(1, 100000));
            freq_val = clk_val + cfg_word_t'($urandom_range(1, 1000));
            apply_timing(clk_val, freq_val);
        end
        else if (mode < 85)
        begin
            apply_timing(cfg_word_t'($urandom), cfg_word_t'($urandom));
        end
        else if (mode < 90)
        begin
            wait_idle();
            write_config(pwmc_pkg::REG_TIMER_CLOCK,
                         cfg_word_t'($urandom_range(1, 200000000)));
            settings_used++;
        end
        else if (mode < 95)
        begin
            wait_idle();
            write_config($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                         cfg_word_t'($urandom));
        end
        else if ($urandom_range(0, 1))
        begin
            apply_timing(cfg_word_t'($urandom_range(1, 200000000)), 28'd0);
        end
        else
        begin
            apply_timing(28'd0, cfg_word_t'($urandom_range(1, 10000000)));
        end
    endtask

    task automatic test_random_traffic();
        int sent;
        int burst;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            pick_random_setting();
            burst = $urandom_range(10, 60);
            repeat (burst)
            begin
                if ($urandom_range(0, 9) < 7)
                    send_word(duty_t'($urandom_range(0, 100)));
                else
                    send_word(duty_t'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    initial
    begin
        words_sent     = 0;
        settings_used  = 1;
        calm_words     = 0;
        clk            = 1'b0;
        clock_hz       = pwmc_pkg::TIMER_CLOCK_RESET;
        freq_hz        = pwmc_pkg::PWM_FREQ_RESET;
        timing_formed  = 1'b0;
        held_prescaler = '0;
        held_period    = '0;
        held_fault     = 1'b0;
        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= pwmc_pkg::REG_TIMER_CLOCK;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        duty_pct     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_timing();
        test_timing_extremes();
        test_fault_cases();
        test_random_traffic();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d duty words over %0d timing settings.", words_sent, settings_used);
        $display("Checked %0d result words, %0d of them with the fault flag set.",
                 results_seen, fault_results);
        if (fail_count == 0)
            $display("PASS pwm_period_and_duty_calculator");
        else
            $display("FAIL pwm_period_and_duty_calculator");
        $finish;
    end

endmodule
